// ----- sv/stq_pkg.sv -----
// Shared types and constants for the sleeping task timer queue.
`timescale 1ns / 1ps

package stq_pkg;

  localparam int COUNT_W = 31;
  localparam int ID_W = 8;
  localparam int KIND_W = 3;
  localparam int MODE_W = 2;
  localparam int DEFAULT_QUEUE_DEPTH = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_DELAY = 2'd1,
    MODE_UNTIL = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_RELEASE  = 3'd0,
    KIND_TIME     = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_cmd_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_cmd_t          cmd;
    logic [COUNT_W-1:0] new_deadline;
    logic [ID_W-1:0]    new_owner;
  } cell_ctl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic [COUNT_W-1:0] deadline;
    logic [ID_W-1:0]    owner;
    logic               le;  // Empty, or deadline no later than the one being inserted.
  } cell_link_t;

endpackage

// ----- sv/stq_cell.sv -----
// One slot of the sorted timer chain: holds a deadline and its owner.
`timescale 1ns / 1ps

module stq_cell (
  input  logic                clk,
  input  stq_pkg::cell_ctl_t  ctl,
  input  logic                occupied,
  input  stq_pkg::cell_link_t left,
  input  stq_pkg::cell_link_t right,
  output stq_pkg::cell_link_t self_link
);

  logic [stq_pkg::COUNT_W-1:0] deadline;
  logic [stq_pkg::COUNT_W-1:0] deadline_next;
  logic [stq_pkg::ID_W-1:0]    owner;
  logic [stq_pkg::ID_W-1:0]    owner_next;
  logic                        own_le;

  assign own_le = !occupied || (deadline <= ctl.new_deadline);

  always_comb begin
    deadline_next = deadline;
    owner_next = owner;
    case (ctl.cmd)
      stq_pkg::CELL_INSERT: begin
        // Entries later than the new deadline move one slot toward the tail.
        if (!left.le) begin
          deadline_next = left.deadline;
          owner_next = left.owner;
        end else if (!own_le || !occupied) begin
          deadline_next = ctl.new_deadline;
          owner_next = ctl.new_owner;
        end
      end
      stq_pkg::CELL_POP: begin
        deadline_next = right.deadline;
        owner_next = right.owner;
      end
      default: begin
        deadline_next = deadline;
        owner_next = owner;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    deadline <= deadline_next;
    owner <= owner_next;
  end

  assign self_link = '{deadline: deadline, owner: owner, le: own_le};

endmodule

// ----- sv/sleeping_task_timer_queue_unit.sv -----
// Top level: tick counter, request control and the chain of timer cells.
//
//   channel  dir  ports                                      carries
//   s        in   s_tvalid s_tready s_tdata s_tuser          one request, mode in s_tuser
//   m        out  m_tvalid m_tready m_tdata m_tuser m_tlast  one result, kind in m_tuser
//
// A delay, delay-until or query request puts its result, if any, in the output register on
// the next cycle. A tick is accepted first; then each released task, up to
// QUEUE_DEPTH of them, leaves through the head cell, and the done result follows.
// Synchronous reset clears the count and the occupancy but not the cell contents.
// A low m_tready holds the result and pauses the release scan.
// No request is accepted until the tick is done.
`timescale 1ns / 1ps

module sleeping_task_timer_queue_unit #(
  parameter int QUEUE_DEPTH = stq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // task_id [7:0], amount [38:8], zero [39]
  input  logic [1:0]  s_tuser,   // mode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // task_id_res [7:0], value [38:8], zero [39]
  output logic [2:0]  m_tuser,   // kind [2:0]
  output logic        m_tlast
);

  localparam int OccW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = stq_pkg::COUNT_W;
  localparam int IW = stq_pkg::ID_W;

  stq_pkg::state_t state;
  stq_pkg::state_t state_next;
  logic [CW-1:0]   tick_count;
  logic [CW-1:0]   tick_count_next;
  logic [OccW-1:0] occupancy;
  logic [OccW-1:0] occupancy_next;

  logic [IW-1:0]   req_id;
  logic [CW-1:0]   req_amount;
  stq_pkg::mode_t  req_mode;
  logic [CW:0]     rel_sum;
  logic            overflow;
  logic            full;
  logic            s_acc;
  logic            out_free;
  logic            release_ok;
  logic            insert_go;

  logic              out_load;
  stq_pkg::kind_t    out_kind;
  logic [IW-1:0]     out_id;
  logic [CW-1:0]     out_value;
  logic              out_last;

  stq_pkg::cell_ctl_t  ctl;
  stq_pkg::cell_link_t links [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occupied;

  assign req_id = s_tdata[IW-1:0];
  assign req_amount = s_tdata[IW+CW-1:IW];
  assign req_mode = stq_pkg::mode_t'(s_tuser);
  assign rel_sum = {1'b0, tick_count} + {1'b0, req_amount};
  assign overflow = rel_sum[CW];
  assign full = (occupancy == OccW'(QUEUE_DEPTH));
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == stq_pkg::ST_IDLE) && out_free;
  assign s_acc = s_tvalid && s_tready;
  assign release_ok = (occupancy != '0) && (links[0].deadline <= tick_count);

  // The chain
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      stq_pkg::cell_link_t left_in;
      stq_pkg::cell_link_t right_in;

      assign occupied[gi] = (OccW'(gi) < occupancy);

      if (gi == 0) begin : g_head
        assign left_in = '{deadline: '0, owner: '0, le: 1'b1};
      end else begin : g_body
        assign left_in = links[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_in = links[gi];
      end else begin : g_inner
        assign right_in = links[gi+1];
      end

      stq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occupied  (occupied[gi]),
        .left      (left_in),
        .right     (right_in),
        .self_link (links[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    tick_count_next = tick_count;
    occupancy_next = occupancy;
    out_load = 1'b0;
    out_kind = stq_pkg::KIND_DONE;
    out_id = '0;
    out_value = '0;
    out_last = 1'b1;
    insert_go = 1'b0;
    ctl.cmd = stq_pkg::CELL_HOLD;
    ctl.new_deadline = (req_mode == stq_pkg::MODE_DELAY) ? rel_sum[CW-1:0] : req_amount;
    ctl.new_owner = req_id;

    case (state)
      stq_pkg::ST_IDLE: begin
        if (s_acc) begin
          case (req_mode)
            stq_pkg::MODE_TICK: begin
              if (tick_count != stq_pkg::COUNT_MAX) begin
                tick_count_next = tick_count + CW'(1);
              end
              state_next = stq_pkg::ST_SCAN;
            end
            stq_pkg::MODE_DELAY: begin
              if (overflow) begin
                out_load = 1'b1;
                out_kind = stq_pkg::KIND_OVERFLOW;
                out_id = req_id;
              end else if (full) begin
                out_load = 1'b1;
                out_kind = stq_pkg::KIND_FULL;
                out_id = req_id;
              end else begin
                insert_go = 1'b1;
              end
            end
            stq_pkg::MODE_UNTIL: begin
              // A deadline already reached releases the task without storing it.
              if (req_amount <= tick_count) begin
                out_load = 1'b1;
                out_kind = stq_pkg::KIND_RELEASE;
                out_id = req_id;
              end else if (full) begin
                out_load = 1'b1;
                out_kind = stq_pkg::KIND_FULL;
                out_id = req_id;
              end else begin
                insert_go = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
              out_kind = stq_pkg::KIND_TIME;
              out_id = req_id;
              out_value = tick_count;
            end
          endcase
          if (insert_go) begin
            ctl.cmd = stq_pkg::CELL_INSERT;
            occupancy_next = occupancy + OccW'(1);
          end
        end
      end
      stq_pkg::ST_SCAN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (release_ok) begin
            out_kind = stq_pkg::KIND_RELEASE;
            out_id = links[0].owner;
            out_last = 1'b0;
            ctl.cmd = stq_pkg::CELL_POP;
            occupancy_next = occupancy - OccW'(1);
          end else begin
            state_next = stq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = stq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::ST_IDLE;
      tick_count <= '0;
      occupancy <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      tick_count <= tick_count_next;
      occupancy <= occupancy_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, out_value, out_id};
      m_tuser <= out_kind;
      m_tlast <= out_last;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OccW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == stq_pkg::ST_IDLE)
    else $error("request accepted outside idle");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (s_acc && insert_go) |=> occupancy == $past(occupancy) + OccW'(1))
    else $error("insert did not grow occupancy");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == stq_pkg::ST_SCAN && out_free && release_ok)
      |=> occupancy == $past(occupancy) - OccW'(1))
    else $error("release did not shrink occupancy");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == stq_pkg::ST_SCAN && out_free && !release_ok)
      |=> (state == stq_pkg::ST_IDLE && m_tvalid && m_tlast))
    else $error("tick scan did not end with done");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the sleeping task timer queue unit.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = stq_pkg::DEFAULT_QUEUE_DEPTH;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    stq_pkg::kind_t              kind;
    logic [stq_pkg::ID_W-1:0]    id;
    logic [stq_pkg::COUNT_W-1:0] value;
    logic                        last;
  } timer_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // task_id [7:0], amount [38:8], zero [39]
  logic [1:0]  s_tuser = stq_pkg::MODE_QUERY;   // mode [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;   // task_id_res [7:0], value [38:8], zero [39]
  logic [2:0]  m_tuser;   // kind [2:0]
  logic        m_tlast;

  // Predicted state of the timer queue.
  logic [stq_pkg::COUNT_W-1:0] ticks_now = '0;
  logic [stq_pkg::COUNT_W-1:0] sleep_deadline [DEPTH];
  logic [stq_pkg::ID_W-1:0]    sleep_owner [DEPTH];
  int                          sleepers = 0;
  timer_event_t                due_events [$];

  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gapless = 1'b0;
  int requests_by_mode [4] = '{default: 0};
  int results_by_kind [5] = '{default: 0};
  int release_run = 0;
  int longest_release_run = 0;

  sleeping_task_timer_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  function automatic void push_event(stq_pkg::kind_t kind, logic [stq_pkg::ID_W-1:0] id,
                                     logic [stq_pkg::COUNT_W-1:0] value, logic last);
    timer_event_t ev;
    ev.kind = kind;
    ev.id = id;
    ev.value = value;
    ev.last = last;
    due_events.push_back(ev);
  endfunction

  // Places a sleeper after every entry whose deadline is no later than its own.
  function automatic void store_sleeper(logic [stq_pkg::COUNT_W-1:0] deadline,
                                        logic [stq_pkg::ID_W-1:0] id);
    int pos;
    int i;
    if (sleepers >= DEPTH) begin
      push_event(stq_pkg::KIND_FULL, id, '0, 1'b1);
      return;
    end
    pos = 0;
    while (pos < sleepers && sleep_deadline[pos] <= deadline) pos++;
    for (i = sleepers; i > pos; i--) begin
      sleep_deadline[i] = sleep_deadline[i-1];
      sleep_owner[i] = sleep_owner[i-1];
    end
    sleep_deadline[pos] = deadline;
    sleep_owner[pos] = id;
    sleepers++;
  endfunction

  function automatic void predict_request(stq_pkg::mode_t mode, logic [stq_pkg::ID_W-1:0] id,
                                          logic [stq_pkg::COUNT_W-1:0] amt);
    logic [stq_pkg::COUNT_W:0] sum;
    int i;
    sum = {1'b0, ticks_now} + {1'b0, amt};
    case (mode)
      stq_pkg::MODE_TICK: begin
        if (ticks_now != stq_pkg::COUNT_MAX) ticks_now++;
        while (sleepers > 0 && sleep_deadline[0] <= ticks_now) begin
          push_event(stq_pkg::KIND_RELEASE, sleep_owner[0], '0, 1'b0);
          for (i = 1; i < sleepers; i++) begin
            sleep_deadline[i-1] = sleep_deadline[i];
            sleep_owner[i-1] = sleep_owner[i];
          end
          sleepers--;
        end
        push_event(stq_pkg::KIND_DONE, '0, '0, 1'b1);
      end
      stq_pkg::MODE_DELAY: begin
        // The overflow check comes ahead of the full check.
        if (sum > {1'b0, stq_pkg::COUNT_MAX}) begin
          push_event(stq_pkg::KIND_OVERFLOW, id, '0, 1'b1);
        end else begin
          store_sleeper(sum[stq_pkg::COUNT_W-1:0], id);
        end
      end
      stq_pkg::MODE_UNTIL: begin
        if (amt <= ticks_now) push_event(stq_pkg::KIND_RELEASE, id, '0, 1'b1);
        else store_sleeper(amt, id);
      end
      default: push_event(stq_pkg::KIND_TIME, id, ticks_now, 1'b1);
    endcase
  endfunction

  // Drives one request, holding it until the transaction completes.
  task automatic send_request(stq_pkg::mode_t mode, logic [stq_pkg::ID_W-1:0] id,
                              logic [stq_pkg::COUNT_W-1:0] amt);
    int gap;
    if (burst_left == 0) begin
      gap = gapless ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, amt, id};
    s_tuser <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    requests_by_mode[mode]++;
    predict_request(mode, id, amt);
  endtask

  task automatic quiet_sender();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    quiet_sender();
    while (due_events.size() != 0) @(posedge clk);
  endtask

  function automatic logic [stq_pkg::ID_W-1:0] any_id();
    return stq_pkg::ID_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [stq_pkg::COUNT_W-1:0] any_amount();
    return stq_pkg::COUNT_W'($urandom());
  endfunction

  task automatic test_directed();
    send_request(stq_pkg::MODE_QUERY, 8'd255, '0);
    send_request(stq_pkg::MODE_TICK, 8'd0, '0);
    send_request(stq_pkg::MODE_UNTIL, 8'd0, '0);           // deadline already passed
    send_request(stq_pkg::MODE_UNTIL, 8'd1, 31'd1);        // deadline equal to the count
    send_request(stq_pkg::MODE_DELAY, 8'd255, '0);         // due on the next tick
    send_request(stq_pkg::MODE_DELAY, 8'd10, 31'd2);
    send_request(stq_pkg::MODE_DELAY, 8'd11, 31'd2);       // tie keeps arrival order
    send_request(stq_pkg::MODE_UNTIL, 8'd12, 31'd3);       // tie from an absolute request
    send_request(stq_pkg::MODE_DELAY, 8'd13, 31'd1);
    send_request(stq_pkg::MODE_TICK, any_id(), any_amount());
    send_request(stq_pkg::MODE_TICK, any_id(), any_amount());
    // Largest deadline that still fits; this task never wakes.
    send_request(stq_pkg::MODE_DELAY, 8'h5A, stq_pkg::COUNT_MAX - ticks_now);
    send_request(stq_pkg::MODE_DELAY, 8'hA5, stq_pkg::COUNT_MAX);
    send_request(stq_pkg::MODE_DELAY, 8'h3C, stq_pkg::COUNT_MAX - ticks_now + 31'd1);
    send_request(stq_pkg::MODE_UNTIL, 8'h33, stq_pkg::COUNT_MAX);
    send_request(stq_pkg::MODE_QUERY, 8'h00, stq_pkg::COUNT_MAX);
    send_request(stq_pkg::MODE_TICK, 8'hFF, stq_pkg::COUNT_MAX);
    send_request(stq_pkg::MODE_QUERY, 8'h81, 31'h2AAA_AAAA);
  endtask

  task automatic test_full_store();
    // Nearly all sleepers share one deadline so that a single tick releases them.
    while (sleepers < DEPTH) begin
      if ($urandom_range(0, 3) == 0) begin
        send_request(stq_pkg::MODE_UNTIL, any_id(), ticks_now + 31'd1);
      end else begin
        send_request(stq_pkg::MODE_DELAY, any_id(), 31'd1);
      end
    end
    send_request(stq_pkg::MODE_DELAY, any_id(), 31'd5);
    send_request(stq_pkg::MODE_UNTIL, any_id(), ticks_now + 31'd9);
    send_request(stq_pkg::MODE_DELAY, any_id(), stq_pkg::COUNT_MAX);
    send_request(stq_pkg::MODE_UNTIL, any_id(), '0);
    send_request(stq_pkg::MODE_QUERY, any_id(), any_amount());
    wait_drain();
    send_request(stq_pkg::MODE_TICK, any_id(), any_amount());
    send_request(stq_pkg::MODE_TICK, any_id(), any_amount());
  endtask

  task automatic test_random(int items);
    int n;
    int pick;
    int unsigned lo;
    for (n = 0; n < items; n++) begin
      if (n % 120 == 119) begin
        wait_drain();
        gapless = !gapless;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_request(stq_pkg::MODE_TICK, any_id(), any_amount());
      end else if (pick < 60) begin
        send_request(stq_pkg::MODE_DELAY, any_id(),
                     stq_pkg::COUNT_W'($urandom_range(0, 24)));
      end else if (pick < 78) begin
        send_request(stq_pkg::MODE_UNTIL, any_id(),
                     stq_pkg::COUNT_W'($urandom_range(0, ticks_now + 24)));
      end else if (pick < 88) begin
        send_request(stq_pkg::MODE_QUERY, any_id(), any_amount());
      end else begin
        lo = 32'(stq_pkg::COUNT_MAX) - 32'(ticks_now) + 1;
        send_request(stq_pkg::MODE_DELAY, any_id(),
                     stq_pkg::COUNT_W'($urandom_range(lo, 32'(stq_pkg::COUNT_MAX))));
      end
    end
    gapless = 1'b0;
  endtask

  // The result sink alternates between steady, random and sparse acceptance.
  always @(posedge clk) begin
    int phase;
    phase = ($time / 2560) % 4;
    case (phase)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= ($time / 10) % 4 == 0;
      default: m_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    timer_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_events.size() == 0) begin
        $error("unexpected result: kind %0d task %0d value %0d",
               m_tuser, m_tdata[7:0], m_tdata[38:8]);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        check_field("kind", want.kind, m_tuser);
        check_field("task_id_res", want.id, m_tdata[7:0]);
        check_field("value", want.value, m_tdata[38:8]);
        check_field("last", want.last, m_tlast);
        check_field("tdata pad", 0, m_tdata[39]);
        if (m_tuser <= stq_pkg::KIND_OVERFLOW) results_by_kind[m_tuser]++;
        if (m_tuser == stq_pkg::KIND_RELEASE && !m_tlast) begin
          release_run++;
          if (release_run > longest_release_run) longest_release_run = release_run;
        end else begin
          release_run = 0;
        end
      end
    end
  end

  // Ends the run if no transaction happens on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sleeping_task_timer_queue_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random(350);
    wait_drain();
    repeat (DEPTH + 4) @(posedge clk);
    $display("Requests: %0d tick, %0d delay, %0d delay-until, %0d query.",
             requests_by_mode[stq_pkg::MODE_TICK], requests_by_mode[stq_pkg::MODE_DELAY],
             requests_by_mode[stq_pkg::MODE_UNTIL], requests_by_mode[stq_pkg::MODE_QUERY]);
    $display("Results: %0d release, %0d time, %0d done, %0d full, %0d overflow; %0d %s",
             results_by_kind[stq_pkg::KIND_RELEASE], results_by_kind[stq_pkg::KIND_TIME],
             results_by_kind[stq_pkg::KIND_DONE], results_by_kind[stq_pkg::KIND_FULL],
             results_by_kind[stq_pkg::KIND_OVERFLOW], longest_release_run,
             "releases in one tick at most.");
    if (mismatches == 0) begin
      $display("sleeping_task_timer_queue_unit verification clean");
    end else begin
      $display("sleeping_task_timer_queue_unit verification failed");
    end
    $finish;
  end

endmodule
